// ----- sv/bitplane_to_chunky_converter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Bitplane to chunky converter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_TO_CHUNKY_CONVERTER_UNIT_DEFINES_SVH
`define BITPLANE_TO_CHUNKY_CONVERTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B2C_ASSERT_HOLD(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b2c assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define B2C_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b2c assertion failed");

`endif

// ----- sv/b2c_pkg.sv -----
// ----------------------------------------------------------------------------
// b2c_pkg
// Constants, register indexes and shared types of the bitplane converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2c_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_PLANES   = 8;
  localparam int HEIGHT_LIMIT = 1024;

  localparam int ROW_STRIDE  = ((MAX_WIDTH + 15) / 16) * 2;
  localparam int STORE_LANES = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
  localparam int STORE_W     = STORE_LANES * 8;

  localparam int BP_W    = (ROW_STRIDE > 1) ? $clog2(ROW_STRIDE) : 1;
  localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W   = 11;
  localparam int PL_W    = 4;
  localparam int RB_W    = $clog2(ROW_STRIDE + 1);
  localparam int SH_W    = 2;
  localparam int N_W     = 4;
  localparam int IDX_W   = 3;
  localparam int CMP_W   = ((BP_W + 4) > (DIM_W + 1)) ? BP_W + 4 : DIM_W + 1;
  localparam int PC_W    = PL_W + 1;

  localparam int PADDR_W    = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FILE_PLANES  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_USED_PLANES  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PACK_ENABLE  = 3'd4;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd200;
  localparam logic [PL_W-1:0]  RST_FILE_PLANES  = 4'd5;
  localparam logic [PL_W-1:0]  RST_USED_PLANES  = 4'd5;

  typedef struct packed {
    logic [DIM_W-1:0] limit;
    logic [RB_W-1:0]  rowbytes;
    logic [DIM_W-1:0] height;
    logic [PL_W-1:0]  fp;
    logic [PL_W-1:0]  up;
    logic [SH_W-1:0]  ppb_log;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [BP_W-1:0]    addr;
    logic [STORE_LANES-1:0] wbe;
    logic [STORE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic            valid;
    logic [7:0]      data;
    logic [BP_W-1:0] bp;
    logic            last_row;
  } col_req_t;

endpackage

`default_nettype wire

// ----- sv/b2c_ram.sv -----
// ----------------------------------------------------------------------------
// b2c_ram
// Generic simple dual-port RAM with byte write enables and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module b2c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH/8-1:0]       wbe,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH / 8; i++) begin
        if (wbe[i]) begin
          mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/b2c_regs.sv -----
// ----------------------------------------------------------------------------
// b2c_regs
// Configuration register file with clamping of the raw settings.
// ----------------------------------------------------------------------------
`default_nettype none

module b2c_regs import b2c_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  logic [PL_W-1:0]      file_planes;
  logic [PL_W-1:0]      used_planes;
  logic                 pack_enable;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr;
  logic [DIM_W-1:0]     w;
  logic [DIM_W:0]       wsum;
  logic [PL_W-1:0]      fp;
  logic [PL_W-1:0]      up;
  logic                 pack;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      file_planes  <= RST_FILE_PLANES;
      used_planes  <= RST_USED_PLANES;
      pack_enable  <= 1'b0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_FILE_PLANES:  file_planes  <= pwdata[PL_W-1:0];
        REG_USED_PLANES:  used_planes  <= pwdata[PL_W-1:0];
        REG_PACK_ENABLE:  pack_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      REG_FILE_PLANES:  prdata = APB_DATA_W'(file_planes);
      REG_USED_PLANES:  prdata = APB_DATA_W'(used_planes);
      REG_PACK_ENABLE:  prdata = APB_DATA_W'(pack_enable);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width == '0) begin
      w = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = image_width;
    end

    if (image_height == '0) begin
      cfg.height = DIM_W'(1);
    end else if (image_height > DIM_W'(HEIGHT_LIMIT)) begin
      cfg.height = DIM_W'(HEIGHT_LIMIT);
    end else begin
      cfg.height = image_height;
    end

    if (file_planes == '0) begin
      fp = PL_W'(1);
    end else if (file_planes > PL_W'(MAX_PLANES)) begin
      fp = PL_W'(MAX_PLANES);
    end else begin
      fp = file_planes;
    end

    if (used_planes == '0) begin
      up = PL_W'(1);
    end else if (used_planes > fp) begin
      up = fp;
    end else begin
      up = used_planes;
    end

    pack = pack_enable && (up == PL_W'(1) || up == PL_W'(2) || up == PL_W'(4));

    priority if (!pack) begin
      cfg.ppb_log = SH_W'(0);
    end else if (up == PL_W'(1)) begin
      cfg.ppb_log = SH_W'(3);
    end else if (up == PL_W'(2)) begin
      cfg.ppb_log = SH_W'(2);
    end else begin
      cfg.ppb_log = SH_W'(1);
    end

    wsum         = (DIM_W + 1)'(w) + (DIM_W + 1)'(15);
    cfg.rowbytes = RB_W'({wsum[DIM_W:4], 1'b0});
    cfg.limit    = (w >> cfg.ppb_log) << cfg.ppb_log;
    cfg.fp       = fp;
    cfg.up       = up;
  end

endmodule

`default_nettype wire

// ----- sv/b2c_front.sv -----
// ----------------------------------------------------------------------------
// b2c_front
// Input side: position counters, line store writes and column read requests.
// ----------------------------------------------------------------------------
`default_nettype none

module b2c_front import b2c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       col_take,
  output col_req_t   col,
  output ram_req_t   ram_req
);

  logic [BP_W-1:0]    bp;
  logic [PLANE_W-1:0] plane;
  logic [ROW_W-1:0]   row;
  logic               col_valid;
  logic [7:0]         col_data;
  logic [BP_W-1:0]    col_bp;
  logic               col_last_row;
  logic               accept;
  logic               last_plane;
  logic               last_row;
  logic               last_byte;

  assign in_ready   = !col_valid || col_take;
  assign accept     = in_valid && in_ready;
  assign last_plane = ((PC_W)'(plane) + (PC_W)'(1)) >= (PC_W)'(cfg.fp);
  assign last_row   = ((DIM_W + 1)'(row) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(cfg.height);
  assign last_byte  = ((RB_W + 1)'(bp) + (RB_W + 1)'(1)) >= (RB_W + 1)'(cfg.rowbytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      bp        <= '0;
      plane     <= '0;
      row       <= '0;
      col_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          bp <= '0;
          if (last_plane) begin
            plane <= '0;
            row   <= last_row ? '0 : row + ROW_W'(1);
          end else begin
            plane <= plane + PLANE_W'(1);
          end
        end else begin
          bp <= bp + BP_W'(1);
        end
      end
      if (accept && last_plane) begin
        col_valid <= 1'b1;
      end else if (col_take) begin
        col_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_plane) begin
      col_data     <= in_data;
      col_bp       <= bp;
      col_last_row <= last_row;
    end
  end

  always_comb begin
    col.valid    = col_valid;
    col.data     = col_data;
    col.bp       = col_bp;
    col.last_row = col_last_row;

    ram_req.we    = accept && !last_plane;
    ram_req.re    = accept && last_plane;
    ram_req.addr  = bp;
    ram_req.wbe   = (STORE_LANES)'(1) << plane;
    ram_req.wdata = {STORE_LANES{in_data}};
  end

endmodule

`default_nettype wire

// ----- sv/b2c_emit.sv -----
// ----------------------------------------------------------------------------
// b2c_emit
// Gathers a byte column into chunky pixels, packs them and sends the words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitplane_to_chunky_converter_unit_defines.svh"

module b2c_emit import b2c_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  col_req_t           col,
  input  logic [STORE_W-1:0] rdata,
  output logic               col_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_data,
  output logic               out_last,
  output logic [1:0]         out_user
);

  logic [7:0]       src [MAX_PLANES];
  logic [7:0]       pix [8];
  logic [7:0]       word [8];
  logic [CMP_W-1:0] base;
  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] diff;
  logic             in_row;
  logic [N_W-1:0]   nvalid;
  logic [N_W-1:0]   n_words;
  logic             col_row_end;

  logic             em_valid;
  logic [7:0]       em_word [8];
  logic [N_W-1:0]   em_n;
  logic [IDX_W-1:0] em_idx;
  logic             em_re;
  logic             em_lr;
  logic             em_last;
  logic             free;

  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      src[p] = '0;
    end
    for (int p = 0; p < STORE_LANES; p++) begin
      src[p] = rdata[p*8 +: 8];
    end
    for (int p = 0; p < MAX_PLANES; p++) begin
      if ((PC_W)'(p) + (PC_W)'(1) == (PC_W)'(cfg.fp)) begin
        src[p] = col.data;
      end
    end

    for (int k = 0; k < 8; k++) begin
      pix[k] = '0;
      for (int p = 0; p < MAX_PLANES; p++) begin
        pix[k][p] = ((PC_W)'(p) < (PC_W)'(cfg.up)) && src[p][7-k];
      end
    end

    for (int g = 0; g < 8; g++) begin
      word[g] = '0;
    end
    unique case (cfg.ppb_log)
      2'd0: begin
        for (int k = 0; k < 8; k++) begin
          word[k] = pix[k];
        end
      end
      2'd1: begin
        for (int g = 0; g < 4; g++) begin
          for (int s = 0; s < 2; s++) begin
            word[g][4*s +: 4] = pix[2*g+s][3:0];
          end
        end
      end
      2'd2: begin
        for (int g = 0; g < 2; g++) begin
          for (int s = 0; s < 4; s++) begin
            word[g][2*s +: 2] = pix[4*g+s][1:0];
          end
        end
      end
      2'd3: begin
        for (int s = 0; s < 8; s++) begin
          word[0][s] = pix[s][0];
        end
      end
    endcase

    base   = (CMP_W)'({col.bp, 3'b000});
    lim    = (CMP_W)'(cfg.limit);
    diff   = lim - base;
    in_row = lim > base;
    if (!in_row) begin
      nvalid = '0;
    end else if (diff >= (CMP_W)'(8)) begin
      nvalid = N_W'(8);
    end else begin
      nvalid = N_W'(diff);
    end
    n_words     = nvalid >> cfg.ppb_log;
    col_row_end = in_row && (lim <= base + (CMP_W)'(8));
  end

  assign em_last  = ((N_W)'(em_idx) + (N_W)'(1)) == em_n;
  assign free     = !em_valid || (out_ready && em_last);
  assign col_take = col.valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_idx   <= '0;
    end else if (col_take) begin
      em_valid <= n_words != '0;
      em_idx   <= '0;
    end else if (em_valid && out_ready) begin
      if (em_last) begin
        em_valid <= 1'b0;
      end else begin
        em_idx <= em_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_take) begin
      em_word <= word;
      em_n    <= n_words;
      em_re   <= col_row_end;
      em_lr   <= col.last_row;
    end
  end

  assign out_valid   = em_valid;
  assign out_data    = em_word[em_idx];
  assign out_last    = em_last;
  assign out_user[0] = em_re && em_last;
  assign out_user[1] = em_re && em_lr && em_last;

  `B2C_ASSERT_HOLD(a_idx_in_range, em_valid, (N_W)'(em_idx) < em_n)
  `B2C_ASSERT_NEXT(a_stall_holds, em_valid && !out_ready,
                   em_valid && $stable(em_idx) && $stable(out_data))
  `B2C_ASSERT_HOLD(a_image_end_on_row_end, out_valid && out_user[1],
                   out_user[0] && out_last)
  `B2C_ASSERT_NEXT(a_take_loads, col_take && (n_words != '0),
                   em_valid && (em_idx == '0))

endmodule

`default_nettype wire

// ----- sv/bitplane_to_chunky_converter_unit.sv -----
// ----------------------------------------------------------------------------
// bitplane_to_chunky_converter_unit
// Interleaved bitplane rows in, chunky pixel bytes out.
// ----------------------------------------------------------------------------
// Input words (s_*) carry decompressed plane bytes in stream order: for each
// row, every file plane's row in turn, each padded to whole 16-bit words.
// Bytes of the earlier planes go into a line store (128 columns by seven
// plane lanes, one write and one read port); such a word is taken every cycle
// unless a gathered column waits. A byte of the last file plane reads its
// column from the store; the byte and the store read are registered, then
// loaded into the output register, and its pixels leave on m_* at one word
// per cycle while m_tready is high, leftmost pixel first. A last-plane byte
// gives up to eight output words, eight in unpacked mode, and the next column
// is loaded as the last of them is taken; store plane bytes give none.
// m_tlast marks the last output word caused by one input word.
// When m_tready is low the current output word holds, one more gathered
// column waits in a holding register, and s_tready falls behind it.
// Reset clears the counters and loads the register defaults; the store is not
// cleared and is only read at columns written earlier in the same row.
// ----------------------------------------------------------------------------
`default_nettype none

module bitplane_to_chunky_converter_unit import b2c_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] plane_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] out_byte
  output logic                  m_tlast,   // run_last
  output logic [1:0]            m_tuser,   // [0] row_end, [1] image_end
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t               cfg;
  col_req_t           col;
  ram_req_t           ram_req;
  logic               col_take;
  logic [STORE_W-1:0] rdata;

  b2c_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  b2c_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .col_take (col_take),
    .col      (col),
    .ram_req  (ram_req)
  );

  b2c_ram #(
    .WIDTH (STORE_W),
    .DEPTH (ROW_STRIDE)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wbe   (ram_req.wbe),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (rdata)
  );

  b2c_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .col       (col),
    .rdata     (rdata),
    .col_take  (col_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_user  (m_tuser)
  );

endmodule

`default_nettype wire

// ----- sim/tb_bitplane_to_chunky_converter_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitplane_to_chunky_converter_unit
// Self-checking bench for the bitplane to chunky pixel converter.
// Register settings are written over the APB port while the unit is idle and
// read back. Interleaved plane rows are then streamed in with random gaps
// while the output side stalls at random. A predictor in the bench keeps its
// own line store, counters and register copies. It works out the chunky words
// that each accepted plane byte should give, and every output word is checked
// field by field against the oldest prediction. The run starts with directed
// images: field extremes, zero and oversized settings, pack mode with and
// without whole bytes, and a file plane change in the middle of a row. Random
// images under many settings follow.
// ----------------------------------------------------------------------------

module tb_bitplane_to_chunky_converter_unit;
  import b2c_pkg::*;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
    logic       rend;
    logic       iend;
  } chunky_word_t;

  typedef struct packed {
    int unsigned w;
    int unsigned h;
    int unsigned fp;
    int unsigned up;
  } geom_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;   // [7:0] plane_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;           // [7:0] out_byte
  logic                  m_tlast;
  logic [1:0]            m_tuser;           // [0] row_end, [1] image_end
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [DIM_W-1:0] width_reg  = RST_IMAGE_WIDTH;
  logic [DIM_W-1:0] height_reg = RST_IMAGE_HEIGHT;
  logic [PL_W-1:0]  fplanes_reg = RST_FILE_PLANES;
  logic [PL_W-1:0]  uplanes_reg = RST_USED_PLANES;
  logic             pack_reg = 1'b0;

  logic [7:0]  plane_rows [0:(MAX_PLANES-1)*ROW_STRIDE];
  int unsigned col_idx = 0;
  int unsigned plane_idx = 0;
  int unsigned row_idx = 0;

  logic [7:0]   pending_bytes [$];
  chunky_word_t expected_words [$];
  chunky_word_t want;
  chunky_word_t got;

  logic s_hs = 1'b0;
  bit   send_quiet = 1'b0;
  bit   recv_quiet = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   errors = 0;
  int   words_in = 0;
  int   words_out = 0;
  int   images_done = 0;
  int   settings = 0;

  bitplane_to_chunky_converter_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("bitplane_to_chunky_converter_unit test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 20) $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic geom_t geometry();
    geom_t g;
    g.w = (width_reg == 0) ? 1 : width_reg;
    g.h = (height_reg == 0) ? 1 : height_reg;
    g.fp = (fplanes_reg == 0) ? 1 : fplanes_reg;
    g.up = (uplanes_reg == 0) ? 1 : uplanes_reg;
    if (g.w > MAX_WIDTH) g.w = MAX_WIDTH;
    if (g.h > HEIGHT_LIMIT) g.h = HEIGHT_LIMIT;
    if (g.fp > MAX_PLANES) g.fp = MAX_PLANES;
    if (g.up > g.fp) g.up = g.fp;
    return g;
  endfunction

  function automatic logic [31:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_IMAGE_WIDTH:  return 32'(width_reg);
      REG_IMAGE_HEIGHT: return 32'(height_reg);
      REG_FILE_PLANES:  return 32'(fplanes_reg);
      REG_USED_PLANES:  return 32'(uplanes_reg);
      default:          return 32'(pack_reg);
    endcase
  endfunction

  task automatic predict_column(input logic [7:0] b);
    geom_t        g;
    int unsigned  rowbytes, ppb, limit, x, acc, pix, src;
    bit           pack, last_row, have;
    chunky_word_t held;
    g = geometry();
    rowbytes = ((g.w + 15) / 16) * 2;
    pack = pack_reg && (g.up == 1 || g.up == 2 || g.up == 4);
    ppb = pack ? 8 / g.up : 1;
    limit = (g.w / ppb) * ppb;
    last_row = (row_idx + 1 >= g.h);
    have = 1'b0;
    acc = 0;
    held = '0;
    if (plane_idx + 1 >= g.fp) begin
      if (col_idx < ROW_STRIDE) begin
        for (int k = 0; k < 8; k++) begin
          x = col_idx * 8 + k;
          if (x >= limit) break;
          pix = 0;
          for (int p = 0; p < g.up; p++) begin
            src = (p + 1 == g.fp) ? b : plane_rows[p * ROW_STRIDE + col_idx];
            pix |= ((src >> (7 - k)) & 1) << p;
          end
          acc |= pack ? (pix << ((x % ppb) * g.up)) : pix;
          if (!pack || x % ppb == ppb - 1) begin
            if (have) expected_words.push_back(held);
            held.pix = acc[7:0];
            held.last = 1'b0;
            held.rend = (x + 1 == limit);
            held.iend = (x + 1 == limit) && last_row;
            have = 1'b1;
            acc = 0;
          end
        end
      end
    end else if (plane_idx + 1 < MAX_PLANES && col_idx < ROW_STRIDE) begin
      plane_rows[plane_idx * ROW_STRIDE + col_idx] = b;
    end
    if (have) begin
      held.last = 1'b1;
      expected_words.push_back(held);
    end
    if (col_idx + 1 >= rowbytes) begin
      col_idx = 0;
      if (plane_idx + 1 >= g.fp) begin
        plane_idx = 0;
        row_idx = last_row ? 0 : row_idx + 1;
      end else begin
        plane_idx++;
      end
    end else begin
      col_idx++;
    end
  endtask

  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nd;
    nv = s_tvalid;
    nd = s_tdata;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || s_hs) begin
      if (send_gap > 0) begin
        nv = 1'b0;
        send_gap--;
      end else if (pending_bytes.size() > 0) begin
        nd = pending_bytes.pop_front();
        nv = 1'b1;
        send_gap = pick_gap(send_quiet);
      end else begin
        nv = 1'b0;
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap(recv_quiet);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_hs <= 1'b0;
    end else begin
      s_hs <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_column(s_tdata);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %02h with nothing expected", m_tdata));
        end else begin
          want = expected_words.pop_front();
          words_out++;
          if (want.iend) images_done++;
          if (got != want)
            report_mismatch($sformatf(
              "word %0d: got pix %02h last %b row_end %b image_end %b, want %02h %b %b %b",
              words_out, got.pix, got.last, got.rend, got.iend,
              want.pix, want.last, want.rend, want.iend));
        end
      end
    end
  end

  task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== reg_value(idx))
      report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, rd,
                                reg_value(idx)));
  endtask

  task automatic reg_access(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = val[DIM_W-1:0];
      REG_FILE_PLANES:  fplanes_reg = val[PL_W-1:0];
      REG_USED_PLANES:  uplanes_reg = val[PL_W-1:0];
      default:          pack_reg = val[0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_read_check(idx);
  endtask

  task automatic set_geometry(input int w, input int h, input int fp, input int up,
                              input int pk);
    reg_access(REG_IMAGE_WIDTH, w);
    reg_access(REG_IMAGE_HEIGHT, h);
    reg_access(REG_FILE_PLANES, fp);
    reg_access(REG_USED_PLANES, up);
    reg_access(REG_PACK_ENABLE, pk);
    settings++;
    send_quiet = ($urandom_range(0, 3) == 0);
    recv_quiet = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [7:0] rand_plane_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int row_length();
    geom_t g;
    g = geometry();
    return ((g.w + 15) / 16) * 2 * g.fp;
  endfunction

  task automatic queue_rows(input int nrows);
    int total;
    total = nrows * row_length();
    repeat (total) pending_bytes.push_back(rand_plane_byte());
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int rand_items;
    int per_row;
    int max_rows;
    int rows;
    int w, h, fp, up, pk;
    bit big_done;
    rand_items = 0;
    big_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 5; i++) reg_read_check(i[REG_IDX_W-1:0]);

    set_geometry(16, 1, 2, 2, 1);
    pending_bytes = '{8'h00, 8'hff, 8'h80, 8'h01};
    wait_idle();

    set_geometry(0, 0, 0, 0, 0);
    pending_bytes = '{8'h80, 8'h7f};
    wait_idle();

    set_geometry(7, 1, 1, 1, 1);
    pending_bytes = '{8'hff, 8'h55};
    wait_idle();

    set_geometry(3, 2047, 15, 15, 1);
    queue_rows(1);
    wait_idle();

    set_geometry(16, 3, 3, 2, 0);
    pending_bytes = '{8'hc3, 8'h5a, 8'hf0, 8'h0f, 8'ha5};
    wait_idle();
    reg_access(REG_FILE_PLANES, 2);
    pending_bytes = '{8'h3c};
    wait_idle();

    while (rand_items < 370) begin
      if (!big_done) begin
        w = $urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047);
        h = 1;
        fp = 1;
        up = 1;
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0:       w = 0;
          1:       w = 1;
          default: w = $urandom_range(2, 40);
        endcase
        case ($urandom_range(0, 9))
          0:       h = 0;
          1:       h = $urandom_range(1025, 2047);
          default: h = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 9))
          0:       fp = 0;
          1:       fp = $urandom_range(9, 15);
          default: fp = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
          0, 1:    up = $urandom_range(0, 15);
          2, 3, 4: up = 1 << $urandom_range(0, 2);
          default: up = $urandom_range(1, (fp == 0) ? 1 : fp);
        endcase
      end
      pk = ($urandom_range(0, 2) != 0);
      set_geometry(w, h, fp, up, pk);
      per_row = row_length();
      max_rows = 90 / per_row;
      if (max_rows < 1) max_rows = 1;
      if (max_rows > 6) max_rows = 6;
      rows = $urandom_range(1, max_rows);
      queue_rows(rows);
      rand_items += rows * per_row;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    while (expected_words.size() != 0) begin
      want = expected_words.pop_front();
      report_mismatch($sformatf("expected word %02h never came", want.pix));
    end
    $display("Streamed %0d plane bytes under %0d register settings.", words_in, settings);
    $display("Checked %0d chunky words, %0d of them image ends.", words_out, images_done);
    if (errors == 0) begin
      $display("bitplane_to_chunky_converter_unit test passed");
    end else begin
      $display("bitplane_to_chunky_converter_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/b2c_pkg.sv
sv/b2c_ram.sv
sv/b2c_regs.sv
sv/b2c_front.sv
sv/b2c_emit.sv
sv/bitplane_to_chunky_converter_unit.sv
sim/tb_bitplane_to_chunky_converter_unit.sv
